// File: rtl/bba_pkg.sv
package bba_pkg;

	// pool geometry
	localparam int MAX_BLOCKS = 256;
	localparam int MAP_BYTES  = MAX_BLOCKS / 8;
	localparam int IDX_W      = $clog2(MAP_BYTES);
	localparam int NB_W       = IDX_W + 1;
	localparam int BLK_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = BLK_W + 1;

	localparam logic [7:0] BYTE_FULL = 8'hFF;
	localparam logic [4:0] MAX_LOG2  = 5'd16;

	// request kinds
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_REGION_BASE    = 2'd0;
	localparam logic [1:0] CFG_BLOCK_LEN_LOG2 = 2'd1;
	localparam logic [1:0] CFG_BLOCK_COUNT    = 2'd2;

	// result status codes
	typedef logic [2:0] status_t;
	localparam status_t STAT_OK        = 3'd0;
	localparam status_t STAT_FULL      = 3'd1;
	localparam status_t STAT_NULL      = 3'd2;
	localparam status_t STAT_BELOW     = 3'd3;
	localparam status_t STAT_ABOVE     = 3'd4;
	localparam status_t STAT_NOT_ALLOC = 3'd5;

	// request to the address unit
	typedef struct packed {
		logic              is_free;
		logic [31:0]       base;
		logic [4:0]        shift;
		logic [CNT_W-1:0]  count;
		logic [BLK_W-1:0]  blk;
		logic [31:0]       addr;
	} addr_req_t;

	// answer from the address unit
	typedef struct packed {
		logic              below;
		logic              above;
		logic [BLK_W-1:0]  blk;
		logic [31:0]       granted;
	} addr_res_t;

endpackage

// File: rtl/bba_ram.sv
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/bba_addr_unit.sv
module bba_addr_unit
	import bba_pkg::*;
(
	input  addr_req_t req,
	output addr_res_t res
);

	logic [31:0] opa;
	logic [31:0] opb;
	logic [32:0] sum;
	logic [31:0] offset;
	logic [31:0] blk_wide;

	// grant offset: block number scaled by the block length
	assign offset = {{(32-BLK_W){1'b0}}, req.blk} << req.shift;

	// one shared adder: base + offset for allocate, addr - base for free
	assign opa = req.is_free ? req.addr : req.base;
	assign opb = req.is_free ? ~req.base : offset;
	assign sum = {1'b0, opa} + {1'b0, opb} + {32'd0, req.is_free};

	// block number of a freed address
	assign blk_wide = sum[31:0] >> req.shift;

	always_comb begin
		res.granted = sum[31:0];
		res.below   = ~sum[32];
		res.above   = blk_wide >= {{(32-CNT_W){1'b0}}, req.count};
		res.blk     = blk_wide[BLK_W-1:0];
	end

endmodule

// File: rtl/bitmap_block_allocator.sv
// Bitmap block allocator: a pool of up to 256 equal power-of-two blocks, one
// map bit per block, held in a 32-byte map memory.
// Input stream: s_axis_tuser is the request kind (0 allocate, 1 free) and
// s_axis_tdata the address to free. Every request yields exactly one result
// transfer on the m_axis stream with status, granted address and block number.
// Configuration writes (region base, block length log2, block count) go over
// the always-ready cfg channel; the user must make them only while idle, as
// the block itself does not enforce it. An allocate reads one map byte per
// cycle until it finds one with a free bit or has examined every map byte;
// a pool with no bytes answers full without a map read. A free goes through
// address check, map read and write-back, and result; a free rejected by the
// address check (null, below, above) skips the map read and write-back. The
// map scan loop through the single memory read port sets the rate.
// One request is worked on at a time; s_axis_tready is high only when idle.
// The result sits in an output register, so a new request is taken while the
// previous result waits; if that result is still not taken when the next one
// is ready, the block holds until the receiver takes it.
// Reset clears the map valid bits at once (every block free) and loads the
// register defaults: base 0, block length log2 6, block count 256.
module bitmap_block_allocator
	import bba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // block_address[31:0]
	input  logic        s_axis_tuser,  // op[0]
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // status[2:0], granted_address[34:3],
	                                   // block_number[42:35], zero fill[47:43]
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FCHK,
		S_FRD,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [31:0]        region_base_q;
	logic [4:0]         block_len_log2_q;
	logic [8:0]         block_count_q;
	logic [31:0]        addr_q;
	logic [IDX_W-1:0]   chk_idx_q;
	logic [BLK_W-1:0]   blk_q;
	logic [MAP_BYTES-1:0] vld_q;
	status_t            res_status_q;
	logic [31:0]        res_addr_q;
	logic [BLK_W-1:0]   res_blk_q;
	logic               out_valid_q;
	logic [47:0]        out_data_q;

	logic [4:0]         eff_shift;
	logic [CNT_W-1:0]   eff_count;
	logic [NB_W-1:0]    nbytes;
	logic [NB_W-1:0]    next_idx;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   rd_idx;
	logic [7:0]         ram_rdata;
	logic [7:0]         rd_byte;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [7:0]         ram_wdata;
	logic [2:0]         zero_pos;
	logic [7:0]         set_mask;
	logic [7:0]         free_mask;
	addr_req_t          areq;
	addr_res_t          ares;
	logic               accept;
	logic               out_free;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign out_free      = !out_valid_q || m_axis_tready;

	// effective configuration
	assign eff_shift = (block_len_log2_q > MAX_LOG2) ? MAX_LOG2 : block_len_log2_q;
	always_comb begin
		eff_count = (block_count_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
		                                                 : block_count_q[CNT_W-1:0];
		eff_count[2:0] = 3'd0;
	end
	assign nbytes   = eff_count[CNT_W-1:3];
	assign next_idx = {1'b0, chk_idx_q} + NB_W'(1);

	// map byte as seen after reset: unwritten bytes read as zero
	assign rd_idx  = (state_q == S_FRD) ? blk_q[BLK_W-1:3] : chk_idx_q;
	assign rd_byte = vld_q[rd_idx] ? ram_rdata : 8'd0;

	// first free bit from the most significant end
	always_comb begin
		zero_pos = 3'd7;
		for (int j = 7; j >= 1; j--) begin
			if (!rd_byte[j] && zero_pos == 3'd7) begin
				zero_pos = 3'(7 - j);
			end
		end
		set_mask  = 8'h80 >> zero_pos;
		free_mask = 8'h80 >> blk_q[2:0];
	end

	// map read address
	always_comb begin
		unique case (state_q)
			S_SCAN:  rd_addr = next_idx[IDX_W-1:0];
			S_FCHK:  rd_addr = ares.blk[BLK_W-1:3];
			default: rd_addr = '0;
		endcase
	end

	// map write-back
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = chk_idx_q;
		ram_wdata = rd_byte | set_mask;
		if (state_q == S_SCAN && rd_byte != BYTE_FULL) begin
			ram_we = 1'b1;
		end else if (state_q == S_FRD) begin
			ram_waddr = blk_q[BLK_W-1:3];
			ram_wdata = rd_byte & ~free_mask;
			ram_we    = (rd_byte & free_mask) != 8'd0;
		end
	end

	// address unit request
	always_comb begin
		areq.is_free = (state_q == S_FCHK);
		areq.base    = region_base_q;
		areq.shift   = eff_shift;
		areq.count   = eff_count;
		areq.blk     = {chk_idx_q, zero_pos};
		areq.addr    = addr_q;
	end

	bba_addr_unit u_addr (
		.req (areq),
		.res (ares)
	);

	bba_ram #(
		.WIDTH (8),
		.DEPTH (MAP_BYTES)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q    <= 32'd0;
			block_len_log2_q <= 5'd6;
			block_count_q    <= 9'd256;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_REGION_BASE:    region_base_q    <= cfg_data;
				CFG_BLOCK_LEN_LOG2: block_len_log2_q <= cfg_data[4:0];
				CFG_BLOCK_COUNT:    block_count_q    <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// map valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ram_we) begin
			vld_q[ram_waddr] <= 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			addr_q       <= 32'd0;
			chk_idx_q    <= '0;
			blk_q        <= '0;
			res_status_q <= STAT_OK;
			res_addr_q   <= 32'd0;
			res_blk_q    <= '0;
			out_data_q   <= 48'd0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						addr_q     <= s_axis_tdata;
						chk_idx_q  <= '0;
						res_addr_q <= 32'd0;
						if (s_axis_tuser == OP_FREE) begin
							state_q <= S_FCHK;
						end else if (nbytes == '0) begin
							res_status_q <= STAT_FULL;
							res_blk_q    <= '0;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rd_byte != BYTE_FULL) begin
						res_status_q <= STAT_OK;
						res_addr_q   <= ares.granted;
						res_blk_q    <= {chk_idx_q, zero_pos};
						state_q      <= S_DONE;
					end else if (next_idx >= nbytes) begin
						res_status_q <= STAT_FULL;
						res_blk_q    <= '0;
						state_q      <= S_DONE;
					end else begin
						chk_idx_q <= next_idx[IDX_W-1:0];
					end
				end
				S_FCHK: begin
					res_blk_q <= '0;
					blk_q     <= ares.blk;
					if (addr_q == 32'd0) begin
						res_status_q <= STAT_NULL;
						state_q      <= S_DONE;
					end else if (ares.below) begin
						res_status_q <= STAT_BELOW;
						state_q      <= S_DONE;
					end else if (ares.above) begin
						res_status_q <= STAT_ABOVE;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_FRD;
					end
				end
				S_FRD: begin
					if ((rd_byte & free_mask) == 8'd0) begin
						res_status_q <= STAT_NOT_ALLOC;
						res_blk_q    <= '0;
					end else begin
						res_status_q <= STAT_OK;
						res_blk_q    <= blk_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_data_q <= {5'd0, res_blk_q, res_addr_q, res_status_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
